// ===== rtl/packet_header_classifier_macros.svh =====
// Assertion helpers for the header classifier; all checks are clocked on clk
// and held off while rst_n is low.
`ifndef PACKET_HEADER_CLASSIFIER_MACROS_SVH
`define PACKET_HEADER_CLASSIFIER_MACROS_SVH

`define PHC_ASSERT_IMPLIES(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("header classifier check failed");

`define PHC_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("header classifier check failed");

`endif

// ===== rtl/phc_pkg.sv =====
package phc_pkg;

    localparam int MAX_FRAME_DEF = 2047;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [2:0] L3_IPV4    = 3'd0;
    localparam logic [2:0] L3_IPV6    = 3'd1;
    localparam logic [2:0] L3_ARP     = 3'd2;
    localparam logic [2:0] L3_UNKNOWN = 3'd3;
    localparam logic [2:0] L3_SHORT   = 3'd4;

    localparam logic [3:0] APP_TCP_OTHER = 4'd0;
    localparam logic [3:0] APP_HTTP      = 4'd1;
    localparam logic [3:0] APP_TLS       = 4'd2;
    localparam logic [3:0] APP_SSH       = 4'd3;
    localparam logic [3:0] APP_SMTP      = 4'd4;
    localparam logic [3:0] APP_UDP_OTHER = 4'd5;
    localparam logic [3:0] APP_DNS       = 4'd6;
    localparam logic [3:0] APP_DHCP      = 4'd7;
    localparam logic [3:0] APP_NTP       = 4'd8;
    localparam logic [3:0] APP_QUIC      = 4'd9;
    localparam logic [3:0] APP_MDNS      = 4'd10;
    localparam logic [3:0] APP_NONE      = 4'd11;

    localparam logic [15:0] PORT_HTTP   = 16'd80;
    localparam logic [15:0] PORT_TLS    = 16'd443;
    localparam logic [15:0] PORT_SSH    = 16'd22;
    localparam logic [15:0] PORT_SMTP   = 16'd25;
    localparam logic [15:0] PORT_DNS    = 16'd53;
    localparam logic [15:0] PORT_DHCP_S = 16'd67;
    localparam logic [15:0] PORT_DHCP_C = 16'd68;
    localparam logic [15:0] PORT_NTP    = 16'd123;
    localparam logic [15:0] PORT_MDNS   = 16'd5353;

    localparam logic [10:0] COUNT_MAX = 11'd2047;

    localparam logic [10:0] MIN_ETH_BYTES  = 11'd14;
    localparam logic [10:0] MIN_IPV4_BYTES = 11'd34;
    localparam logic [10:0] MIN_IPV6_BYTES = 11'd21;
    localparam logic [10:0] TCP_HDR_BYTES  = 11'd14;
    localparam logic [10:0] UDP_HDR_BYTES  = 11'd4;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [4:0]  flags;
        logic [6:0]  l4_start;
        logic [10:0] count;
    } frame_rec_t;

    typedef struct packed {
        logic [2:0]  l3_kind;
        logic [15:0] ethertype_value;
        logic [31:0] src_ipv4;
        logic [31:0] dst_ipv4;
        logic [7:0]  hop_ttl;
        logic [7:0]  l4_protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [4:0]  tcp_flag_bits;
        logic [3:0]  app_code;
        logic        truncated;
        logic [10:0] frame_bytes;
    } summary_t;

endpackage

// ===== rtl/phc_byte_if.sv =====
interface phc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/phc_summary_if.sv =====
interface phc_summary_if;
    logic        valid;
    logic        ready;
    logic [2:0]  l3_kind;
    logic [15:0] ethertype_value;
    logic [31:0] src_ipv4;
    logic [31:0] dst_ipv4;
    logic [7:0]  hop_ttl;
    logic [7:0]  l4_protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [4:0]  tcp_flag_bits;
    logic [3:0]  app_code;
    logic        truncated;
    logic [10:0] frame_bytes;

    modport source (
        output valid, output l3_kind, output ethertype_value, output src_ipv4,
        output dst_ipv4, output hop_ttl, output l4_protocol, output src_port,
        output dst_port, output tcp_flag_bits, output app_code, output truncated,
        output frame_bytes, input ready
    );
    modport sink (
        input valid, input l3_kind, input ethertype_value, input src_ipv4,
        input dst_ipv4, input hop_ttl, input l4_protocol, input src_port,
        input dst_port, input tcp_flag_bits, input app_code, input truncated,
        input frame_bytes, output ready
    );
endinterface

// ===== rtl/phc_queue.sv =====
module phc_queue
    import phc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    input  frame_rec_t wr_data,
    output logic       wr_ready,
    output logic       rd_valid,
    output frame_rec_t rd_data,
    input  logic       rd_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign wr_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/phc_front.sv =====
module phc_front
    import phc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    phc_byte_if.sink   frame,
    output logic       rec_valid,
    output frame_rec_t rec,
    input  logic       rec_ready
);

    localparam int OFF_W = $clog2(MAX_FRAME + 1);
    localparam int CW    = (OFF_W > 11) ? OFF_W : 11;

    logic [OFF_W-1:0] offset_reg;
    logic [OFF_W-1:0] offset_next;
    logic [15:0]      ethertype_reg;
    logic [15:0]      ethertype_next;
    logic [6:0]       l4_start_reg;
    logic [6:0]       l4_start_next;
    logic [7:0]       protocol_reg;
    logic [7:0]       protocol_next;
    logic [7:0]       ttl_reg;
    logic [7:0]       ttl_next;
    logic [31:0]      src_addr_reg;
    logic [31:0]      src_addr_next;
    logic [31:0]      dst_addr_reg;
    logic [31:0]      dst_addr_next;
    logic [15:0]      src_port_reg;
    logic [15:0]      src_port_next;
    logic [15:0]      dst_port_reg;
    logic [15:0]      dst_port_next;
    logic [4:0]       flags_reg;
    logic [4:0]       flags_next;

    logic             accept;
    logic             active;
    logic [7:0]       b;
    logic [6:0]       l4_eff;
    logic [OFF_W-1:0] l4_ext;
    logic [OFF_W-1:0] l4_diff;
    logic             in_l4;
    logic [CW-1:0]    count_ext;
    frame_rec_t       cap;

    assign frame.ready = rec_ready;
    assign accept      = frame.valid && frame.ready;
    assign active      = offset_reg < OFF_W'(MAX_FRAME);
    assign b           = frame.data_byte;

    assign l4_eff  = (offset_reg == OFF_W'(14))
                   ? 7'd14 + {1'b0, b[3:0], 2'b00}
                   : l4_start_reg;
    assign l4_ext  = OFF_W'(l4_eff);
    assign l4_diff = offset_reg - l4_ext;
    assign in_l4   = (offset_reg >= OFF_W'(14)) && (offset_reg >= l4_ext);

    always_comb
    begin
        cap.ethertype = ethertype_reg;
        cap.ttl       = ttl_reg;
        cap.protocol  = protocol_reg;
        cap.src_addr  = src_addr_reg;
        cap.dst_addr  = dst_addr_reg;
        cap.src_port  = src_port_reg;
        cap.dst_port  = dst_port_reg;
        cap.flags     = flags_reg;
        cap.l4_start  = l4_start_reg;
        offset_next   = offset_reg;

        if (accept && active)
        begin
            offset_next = offset_reg + 1'b1;
            if (offset_reg == OFF_W'(12))
            begin
                cap.ethertype = {b, 8'h00};
            end
            else if (offset_reg == OFF_W'(13))
            begin
                cap.ethertype = ethertype_reg | {8'h00, b};
            end
            if (offset_reg == OFF_W'(14))
            begin
                cap.l4_start = l4_eff;
            end
            if (offset_reg == OFF_W'(22))
            begin
                cap.ttl = b;
            end
            if (offset_reg == OFF_W'(23) && ethertype_reg == ETH_IPV4)
            begin
                cap.protocol = b;
            end
            if (offset_reg == OFF_W'(20) && ethertype_reg == ETH_IPV6)
            begin
                cap.protocol = b;
            end
            if (offset_reg >= OFF_W'(26) && offset_reg <= OFF_W'(29))
            begin
                cap.src_addr = {src_addr_reg[23:0], b};
            end
            if (offset_reg >= OFF_W'(30) && offset_reg <= OFF_W'(33))
            begin
                cap.dst_addr = {dst_addr_reg[23:0], b};
            end
            if (in_l4)
            begin
                if (l4_diff == OFF_W'(0))
                begin
                    cap.src_port = {b, 8'h00};
                end
                else if (l4_diff == OFF_W'(1))
                begin
                    cap.src_port = {src_port_reg[15:8], b};
                end
                else if (l4_diff == OFF_W'(2))
                begin
                    cap.dst_port = {b, 8'h00};
                end
                else if (l4_diff == OFF_W'(3))
                begin
                    cap.dst_port = {dst_port_reg[15:8], b};
                end
                else if (l4_diff == OFF_W'(13))
                begin
                    cap.flags = {b[3], b[2], b[0], b[4], b[1]};
                end
            end
        end

        count_ext = CW'(offset_next);
        cap.count = (count_ext > CW'(COUNT_MAX)) ? COUNT_MAX : count_ext[10:0];
    end

    assign rec       = cap;
    assign rec_valid = accept && frame.last_byte;

    always_comb
    begin
        if (accept && frame.last_byte)
        begin
            offset_next_clear();
        end
        ethertype_next = rec_valid ? '0 : cap.ethertype;
        l4_start_next  = rec_valid ? '0 : cap.l4_start;
        protocol_next  = rec_valid ? '0 : cap.protocol;
        ttl_next       = rec_valid ? '0 : cap.ttl;
        src_addr_next  = rec_valid ? '0 : cap.src_addr;
        dst_addr_next  = rec_valid ? '0 : cap.dst_addr;
        src_port_next  = rec_valid ? '0 : cap.src_port;
        dst_port_next  = rec_valid ? '0 : cap.dst_port;
        flags_next     = rec_valid ? '0 : cap.flags;
    end

    function automatic void offset_next_clear();
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            ethertype_reg <= '0;
            l4_start_reg  <= '0;
            protocol_reg  <= '0;
            ttl_reg       <= '0;
            src_addr_reg  <= '0;
            dst_addr_reg  <= '0;
            src_port_reg  <= '0;
            dst_port_reg  <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            offset_reg    <= rec_valid ? '0 : offset_next;
            ethertype_reg <= ethertype_next;
            l4_start_reg  <= l4_start_next;
            protocol_reg  <= protocol_next;
            ttl_reg       <= ttl_next;
            src_addr_reg  <= src_addr_next;
            dst_addr_reg  <= dst_addr_next;
            src_port_reg  <= src_port_next;
            dst_port_reg  <= dst_port_next;
            flags_reg     <= flags_next;
        end
    end

endmodule

// ===== rtl/phc_back.sv =====
module phc_back
    import phc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         rec_valid,
    input  frame_rec_t   rec,
    output logic         rec_ready,
    phc_summary_if.source summary
);

    logic     out_valid_reg;
    logic     out_valid_next;
    summary_t out_reg;
    summary_t out_next;
    logic     pop;

    function automatic logic port_hit(input logic [15:0] s, input logic [15:0] d,
                                      input logic [15:0] p);
        return (s == p) || (d == p);
    endfunction

    function automatic logic [3:0] tcp_app(input logic [15:0] s, input logic [15:0] d);
        logic [3:0] code;
        code = APP_TCP_OTHER;
        if (port_hit(s, d, PORT_HTTP))
        begin
            code = APP_HTTP;
        end
        else if (port_hit(s, d, PORT_TLS))
        begin
            code = APP_TLS;
        end
        else if (port_hit(s, d, PORT_SSH))
        begin
            code = APP_SSH;
        end
        else if (port_hit(s, d, PORT_SMTP))
        begin
            code = APP_SMTP;
        end
        return code;
    endfunction

    function automatic logic [3:0] udp_app(input logic [15:0] s, input logic [15:0] d);
        logic [3:0] code;
        code = APP_UDP_OTHER;
        if (port_hit(s, d, PORT_DNS))
        begin
            code = APP_DNS;
        end
        else if (port_hit(s, d, PORT_DHCP_S) || port_hit(s, d, PORT_DHCP_C))
        begin
            code = APP_DHCP;
        end
        else if (port_hit(s, d, PORT_NTP))
        begin
            code = APP_NTP;
        end
        else if (port_hit(s, d, PORT_TLS))
        begin
            code = APP_QUIC;
        end
        else if (port_hit(s, d, PORT_MDNS))
        begin
            code = APP_MDNS;
        end
        return code;
    endfunction

    assign rec_ready = !out_valid_reg || summary.ready;
    assign pop       = rec_valid && rec_ready;

    always_comb
    begin
        out_next             = '0;
        out_next.app_code    = APP_NONE;
        out_next.frame_bytes = rec.count;

        if (rec.count < MIN_ETH_BYTES)
        begin
            out_next.l3_kind   = L3_SHORT;
            out_next.truncated = 1'b1;
        end
        else
        begin
            out_next.ethertype_value = rec.ethertype;
            if (rec.ethertype == ETH_IPV4)
            begin
                out_next.l3_kind = L3_IPV4;
                if (rec.count < MIN_IPV4_BYTES)
                begin
                    out_next.truncated = 1'b1;
                end
                else
                begin
                    out_next.src_ipv4    = rec.src_addr;
                    out_next.dst_ipv4    = rec.dst_addr;
                    out_next.hop_ttl     = rec.ttl;
                    out_next.l4_protocol = rec.protocol;
                    if (rec.protocol == PROTO_TCP)
                    begin
                        if (rec.count < 11'(rec.l4_start) + TCP_HDR_BYTES)
                        begin
                            out_next.truncated = 1'b1;
                        end
                        else
                        begin
                            out_next.src_port      = rec.src_port;
                            out_next.dst_port      = rec.dst_port;
                            out_next.tcp_flag_bits = rec.flags;
                            out_next.app_code      = tcp_app(rec.src_port, rec.dst_port);
                        end
                    end
                    else if (rec.protocol == PROTO_UDP)
                    begin
                        if (rec.count < 11'(rec.l4_start) + UDP_HDR_BYTES)
                        begin
                            out_next.truncated = 1'b1;
                        end
                        else
                        begin
                            out_next.src_port = rec.src_port;
                            out_next.dst_port = rec.dst_port;
                            out_next.app_code = udp_app(rec.src_port, rec.dst_port);
                        end
                    end
                end
            end
            else if (rec.ethertype == ETH_IPV6)
            begin
                out_next.l3_kind = L3_IPV6;
                if (rec.count < MIN_IPV6_BYTES)
                begin
                    out_next.truncated = 1'b1;
                end
                else
                begin
                    out_next.l4_protocol = rec.protocol;
                end
            end
            else if (rec.ethertype == ETH_ARP)
            begin
                out_next.l3_kind = L3_ARP;
            end
            else
            begin
                out_next.l3_kind = L3_UNKNOWN;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (summary.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    assign summary.valid           = out_valid_reg;
    assign summary.l3_kind         = out_reg.l3_kind;
    assign summary.ethertype_value = out_reg.ethertype_value;
    assign summary.src_ipv4        = out_reg.src_ipv4;
    assign summary.dst_ipv4        = out_reg.dst_ipv4;
    assign summary.hop_ttl         = out_reg.hop_ttl;
    assign summary.l4_protocol     = out_reg.l4_protocol;
    assign summary.src_port        = out_reg.src_port;
    assign summary.dst_port        = out_reg.dst_port;
    assign summary.tcp_flag_bits   = out_reg.tcp_flag_bits;
    assign summary.app_code        = out_reg.app_code;
    assign summary.truncated       = out_reg.truncated;
    assign summary.frame_bytes     = out_reg.frame_bytes;

endmodule

// ===== rtl/packet_header_classifier.sv =====
// Ethernet/IPv4/TCP/UDP header classifier. Frame bytes enter on the frame
// channel at one byte per cycle unless stalled, with last_byte set on the
// final byte; each frame yields one summary on the summary channel via the
// queue and the summary register. The front end captures header fields as
// the bytes stream past, and on the last byte hands a record to a two-entry
// queue; the back end classifies the queue head into a registered summary.
// Frame input stalls only when both queue entries hold records the back end
// has not yet taken, so a sink that keeps ready high never stalls the link.
// Bytes past MAX_FRAME are accepted and ignored; frame_bytes saturates there.
`include "packet_header_classifier_macros.svh"

module packet_header_classifier
    import phc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    phc_byte_if.sink      frame,
    phc_summary_if.source summary
);

    logic       front_valid;
    frame_rec_t front_rec;
    logic       front_ready;
    logic       back_valid;
    frame_rec_t back_rec;
    logic       back_ready;

    phc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .rec_valid (front_valid),
        .rec       (front_rec),
        .rec_ready (front_ready)
    );

    phc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_data  (front_rec),
        .wr_ready (front_ready),
        .rd_valid (back_valid),
        .rd_data  (back_rec),
        .rd_ready (back_ready)
    );

    phc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (back_valid),
        .rec       (back_rec),
        .rec_ready (back_ready),
        .summary   (summary)
    );

    `PHC_ASSERT_IMPLIES(a_short_frame, summary.valid && summary.frame_bytes < MIN_ETH_BYTES, summary.l3_kind == L3_SHORT && summary.truncated && summary.app_code == APP_NONE)
    `PHC_ASSERT_IMPLIES(a_ports_ipv4_only, summary.valid && (summary.src_port != 16'd0 || summary.dst_port != 16'd0), summary.l3_kind == L3_IPV4)
    `PHC_ASSERT_IMPLIES(a_app_needs_l4, summary.valid && summary.app_code != APP_NONE, !summary.truncated && summary.l3_kind == L3_IPV4)
    `PHC_ASSERT_NEXT(a_record_reaches_queue, front_valid, back_valid)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import phc_pkg::*;

    localparam int FRAME_CAP     = MAX_FRAME_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_FRAMES = 48;

    logic clk;
    logic rst_n;

    phc_byte_if    frame_ch();
    phc_summary_if sum_ch();

    packet_header_classifier #(.MAX_FRAME(FRAME_CAP)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_ch),
        .summary (sum_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // header tracker state, mirrors the block's view of the current frame
    logic [10:0] ofs;
    logic [15:0] eth_acc;
    logic [6:0]  l4_base;
    logic [7:0]  proto_acc;
    logic [7:0]  ttl_acc;
    logic [31:0] sip_acc;
    logic [31:0] dip_acc;
    logic [15:0] sport_acc;
    logic [15:0] dport_acc;
    logic [4:0]  flag_acc;

    summary_t    pending_summaries[$];
    logic [7:0]  frame_buf[$];
    bit          src_steady;
    int          fail_count;

    task automatic clear_tracker();
        ofs       = '0;
        eth_acc   = '0;
        l4_base   = '0;
        proto_acc = '0;
        ttl_acc   = '0;
        sip_acc   = '0;
        dip_acc   = '0;
        sport_acc = '0;
        dport_acc = '0;
        flag_acc  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        summary_t s;
        int       n;
        if (ofs < FRAME_CAP)
        begin
            if (ofs == 12)
                eth_acc = {b, 8'h00};
            else if (ofs == 13)
                eth_acc[7:0] = b;
            if (ofs == 14)
                l4_base = 7'(14 + int'(b[3:0]) * 4);
            if (ofs == 22)
                ttl_acc = b;
            if (ofs == 23 && eth_acc == ETH_IPV4)
                proto_acc = b;
            if (ofs == 20 && eth_acc == ETH_IPV6)
                proto_acc = b;
            if (ofs >= 26 && ofs <= 29)
                sip_acc = {sip_acc[23:0], b};
            if (ofs >= 30 && ofs <= 33)
                dip_acc = {dip_acc[23:0], b};
            if (ofs >= 14)
            begin
                if (int'(ofs) == int'(l4_base))
                    sport_acc = {b, 8'h00};
                else if (int'(ofs) == int'(l4_base) + 1)
                    sport_acc[7:0] = b;
                else if (int'(ofs) == int'(l4_base) + 2)
                    dport_acc = {b, 8'h00};
                else if (int'(ofs) == int'(l4_base) + 3)
                    dport_acc[7:0] = b;
                else if (int'(ofs) == int'(l4_base) + 13)
                    flag_acc = {b[3], b[2], b[0], b[4], b[1]};
            end
            ofs = ofs + 11'd1;
        end
        if (last)
        begin
            n = int'(ofs);
            s = '0;
            s.app_code    = APP_NONE;
            s.frame_bytes = (n > int'(COUNT_MAX)) ? COUNT_MAX : ofs;
            if (n < int'(MIN_ETH_BYTES))
            begin
                s.l3_kind   = L3_SHORT;
                s.truncated = 1'b1;
            end
            else
            begin
                s.ethertype_value = eth_acc;
                if (eth_acc == ETH_IPV4)
                begin
                    s.l3_kind = L3_IPV4;
                    if (n < int'(MIN_IPV4_BYTES))
                        s.truncated = 1'b1;
                    else
                    begin
                        s.src_ipv4    = sip_acc;
                        s.dst_ipv4    = dip_acc;
                        s.hop_ttl     = ttl_acc;
                        s.l4_protocol = proto_acc;
                        if (proto_acc == PROTO_TCP)
                        begin
                            if (n < int'(l4_base) + int'(TCP_HDR_BYTES))
                                s.truncated = 1'b1;
                            else
                            begin
                                s.src_port      = sport_acc;
                                s.dst_port      = dport_acc;
                                s.tcp_flag_bits = flag_acc;
                                if (sport_acc == PORT_HTTP || dport_acc == PORT_HTTP)
                                    s.app_code = APP_HTTP;
                                else if (sport_acc == PORT_TLS || dport_acc == PORT_TLS)
                                    s.app_code = APP_TLS;
                                else if (sport_acc == PORT_SSH || dport_acc == PORT_SSH)
                                    s.app_code = APP_SSH;
                                else if (sport_acc == PORT_SMTP || dport_acc == PORT_SMTP)
                                    s.app_code = APP_SMTP;
                                else
                                    s.app_code = APP_TCP_OTHER;
                            end
                        end
                        else if (proto_acc == PROTO_UDP)
                        begin
                            if (n < int'(l4_base) + int'(UDP_HDR_BYTES))
                                s.truncated = 1'b1;
                            else
                            begin
                                s.src_port = sport_acc;
                                s.dst_port = dport_acc;
                                if (sport_acc == PORT_DNS || dport_acc == PORT_DNS)
                                    s.app_code = APP_DNS;
                                else if (sport_acc == PORT_DHCP_S || dport_acc == PORT_DHCP_S ||
                                         sport_acc == PORT_DHCP_C || dport_acc == PORT_DHCP_C)
                                    s.app_code = APP_DHCP;
                                else if (sport_acc == PORT_NTP || dport_acc == PORT_NTP)
                                    s.app_code = APP_NTP;
                                else if (sport_acc == PORT_TLS || dport_acc == PORT_TLS)
                                    s.app_code = APP_QUIC;
                                else if (sport_acc == PORT_MDNS || dport_acc == PORT_MDNS)
                                    s.app_code = APP_MDNS;
                                else
                                    s.app_code = APP_UDP_OTHER;
                            end
                        end
                    end
                end
                else if (eth_acc == ETH_IPV6)
                begin
                    s.l3_kind = L3_IPV6;
                    if (n < int'(MIN_IPV6_BYTES))
                        s.truncated = 1'b1;
                    else
                        s.l4_protocol = proto_acc;
                end
                else if (eth_acc == ETH_ARP)
                    s.l3_kind = L3_ARP;
                else
                    s.l3_kind = L3_UNKNOWN;
            end
            pending_summaries.push_back(s);
            clear_tracker();
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        int r;
        gap = 0;
        if (!src_steady)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                gap = 0;
            else if (r < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(4, 30);
        end
        if (gap > 0)
        begin
            frame_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.valid     = 1'b1;
        frame_ch.data_byte = b;
        frame_ch.last_byte = last;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        absorb_byte(b, last);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            push_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    function automatic void set_octet(input int idx, input logic [7:0] v);
        if (idx < frame_buf.size())
            frame_buf[idx] = v;
    endfunction

    // random filler, then header fields placed where they fit inside len
    task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [15:0] sport,
                               input logic [15:0] dport, input logic [7:0] tflags,
                               input int len);
        int base;
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom));
        base = 14 + int'(ihl) * 4;
        set_octet(12, etype[15:8]);
        set_octet(13, etype[7:0]);
        if (etype == ETH_IPV6)
            set_octet(20, proto);
        else if (etype == ETH_IPV4)
        begin
            set_octet(14, {4'($urandom), ihl});
            set_octet(23, proto);
            set_octet(base, sport[15:8]);
            set_octet(base + 1, sport[7:0]);
            set_octet(base + 2, dport[15:8]);
            set_octet(base + 3, dport[7:0]);
            set_octet(base + 13, tflags);
        end
    endtask

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 21))
            0:       return PORT_HTTP;
            1:       return PORT_TLS;
            2:       return PORT_SSH;
            3:       return PORT_SMTP;
            4:       return PORT_DNS;
            5:       return PORT_DHCP_S;
            6:       return PORT_DHCP_C;
            7:       return PORT_NTP;
            8:       return PORT_MDNS;
            9:       return 16'h0000;
            10:      return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_short_frames();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_HTTP, PORT_HTTP, 8'h00, 1);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_HTTP, PORT_HTTP, 8'h00, 13);
        send_frame();
    endtask

    task automatic test_other_ethertypes();
        build_frame(ETH_ARP, 4'd5, 8'h00, 16'h0, 16'h0, 8'h00, 14);
        send_frame();
        build_frame(16'hFFFF, 4'd5, 8'h00, 16'h0, 16'h0, 8'h00, 40);
        send_frame();
        build_frame(16'h0000, 4'd5, 8'h00, 16'h0, 16'h0, 8'h00, 20);
        send_frame();
        build_frame(ETH_IPV6, 4'd5, PROTO_TCP, 16'h0, 16'h0, 8'h00, 20);
        send_frame();
        build_frame(ETH_IPV6, 4'd5, 8'hFF, 16'h0, 16'h0, 8'h00, 21);
        send_frame();
    endtask

    task automatic test_ipv4_tcp();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, 16'd1000, PORT_HTTP, 8'hFF, 60);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_TLS, 16'hFFFF, 8'h00, 48);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_SSH, 16'd0, 8'h12, 48);
        send_frame();
        // first match in list order wins
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_SMTP, PORT_HTTP, 8'h18, 48);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, 16'd4321, PORT_SMTP, 8'h04, 48);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, 16'd4321, 16'd8080, 8'h02, 54);
        send_frame();
    endtask

    task automatic test_ipv4_udp();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, PORT_MDNS, PORT_DNS, 8'h00, 42);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, PORT_DHCP_C, PORT_DHCP_S, 8'h00, 42);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, 16'd5000, PORT_DHCP_C, 8'h00, 38);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, PORT_NTP, PORT_TLS, 8'h00, 38);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, PORT_TLS, PORT_MDNS, 8'h00, 38);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, 16'd7, PORT_MDNS, 8'h00, 38);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, 16'd7, 16'd9, 8'h00, 38);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, 8'd1, PORT_HTTP, PORT_DNS, 8'h00, 60);
        send_frame();
    endtask

    task automatic test_header_cuts();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_HTTP, PORT_HTTP, 8'hFF, 33);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_HTTP, PORT_HTTP, 8'hFF, 47);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, PORT_DNS, PORT_DNS, 8'h00, 37);
        send_frame();
    endtask

    task automatic test_small_ihl();
        // zero low nibble of byte 14 keeps the header length field at zero
        build_frame(ETH_IPV4, 4'd0, PROTO_TCP, PORT_HTTP, PORT_SSH, 8'h1F, 34);
        send_frame();
        build_frame(ETH_IPV4, 4'd1, PROTO_UDP, PORT_DNS, 16'd99, 8'h00, 36);
        send_frame();
        build_frame(ETH_IPV4, 4'd15, PROTO_TCP, PORT_TLS, 16'd2, 8'h0A, 88);
        send_frame();
    endtask

    task automatic test_long_frames();
        src_steady = 1'b1;
        build_frame(ETH_IPV4, 4'd5, PROTO_UDP, PORT_NTP, 16'd1, 8'h00, FRAME_CAP);
        send_frame();
        src_steady = 1'b0;
        build_frame(ETH_IPV6, 4'd5, 8'd58, 16'h0, 16'h0, 8'h00, FRAME_CAP + 1);
        send_frame();
        build_frame(ETH_IPV4, 4'd5, PROTO_TCP, PORT_SSH, 16'd1234, 8'h12, FRAME_CAP + 53);
        send_frame();
    endtask

    task automatic test_random_frames();
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        int          r;
        int          full;
        int          len;
        repeat (RANDOM_FRAMES)
        begin
            src_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
                etype = ETH_IPV4;
            else if (r < 70)
                etype = ETH_IPV6;
            else if (r < 80)
                etype = ETH_ARP;
            else
                etype = 16'($urandom);
            ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd5;
            r = $urandom_range(0, 99);
            if (r < 45)
                proto = PROTO_TCP;
            else if (r < 85)
                proto = PROTO_UDP;
            else
                proto = 8'($urandom);
            if (etype == ETH_IPV4)
            begin
                full = 14 + int'(ihl) * 4 + ((proto == PROTO_TCP) ? 14 : 4);
                if (full < 34)
                    full = 34;
            end
            else if (etype == ETH_IPV6)
                full = 21;
            else
                full = 14;
            full = full + $urandom_range(0, 24);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full) : full;
            build_frame(etype, ihl, proto, pick_port(), pick_port(), 8'($urandom), len);
            send_frame();
        end
        src_steady = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : summary_check
        summary_t want;
        if (rst_n && sum_ch.valid && sum_ch.ready)
        begin
            if (pending_summaries.size() == 0)
            begin
                $error("summary with no frame outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_summaries.pop_front();
                compare_field("l3_kind", want.l3_kind, sum_ch.l3_kind);
                compare_field("ethertype_value", want.ethertype_value,
                              sum_ch.ethertype_value);
                compare_field("src_ipv4", want.src_ipv4, sum_ch.src_ipv4);
                compare_field("dst_ipv4", want.dst_ipv4, sum_ch.dst_ipv4);
                compare_field("hop_ttl", want.hop_ttl, sum_ch.hop_ttl);
                compare_field("l4_protocol", want.l4_protocol, sum_ch.l4_protocol);
                compare_field("src_port", want.src_port, sum_ch.src_port);
                compare_field("dst_port", want.dst_port, sum_ch.dst_port);
                compare_field("tcp_flag_bits", want.tcp_flag_bits, sum_ch.tcp_flag_bits);
                compare_field("app_code", want.app_code, sum_ch.app_code);
                compare_field("truncated", want.truncated, sum_ch.truncated);
                compare_field("frame_bytes", want.frame_bytes, sum_ch.frame_bytes);
            end
        end
    end

    initial
    begin : sink_pacer
        int run;
        sum_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 12);
            sum_ch.ready = 1'b1;
            repeat (run) @(negedge clk);
            run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                : $urandom_range(8, 40);
            sum_ch.ready = 1'b0;
            repeat (run) @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((frame_ch.valid && frame_ch.ready) || (sum_ch.valid && sum_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        fail_count         = 0;
        src_steady         = 1'b0;
        rst_n              = 1'b0;
        frame_ch.valid     = 1'b0;
        frame_ch.data_byte = 8'h00;
        frame_ch.last_byte = 1'b0;
        clear_tracker();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_short_frames();
        test_other_ethertypes();
        test_ipv4_tcp();
        test_ipv4_udp();
        test_header_cuts();
        test_small_ihl();
        test_long_frames();
        test_random_frames();
        frame_ch.valid     = 1'b0;
        frame_ch.last_byte = 1'b0;

        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/phc_pkg.sv
rtl/phc_byte_if.sv
rtl/phc_summary_if.sv
rtl/phc_queue.sv
rtl/phc_front.sv
rtl/phc_back.sv
rtl/packet_header_classifier.sv
dv/testbench.sv
